>>> rtl/rpr_pkg.sv
// shared types, register indexes and product tables of the pose edge residual block
package rpr_pkg;

	// action codes of an input item
	localparam logic ACT_STORE   = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_MEAS_TX  = 3'd0;
	localparam logic [2:0] REG_MEAS_TY  = 3'd1;
	localparam logic [2:0] REG_MEAS_TZ  = 3'd2;
	localparam logic [2:0] REG_MEAS_ROT = 3'd3;
	localparam logic [2:0] REG_TRANS_W  = 3'd4;
	localparam logic [2:0] REG_ROT_W    = 3'd5;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [15:0] qw;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
	} pose_t;

	// one queued edge: stored pose i and the arriving pose j
	typedef struct packed {
		pose_t pi;
		pose_t pj;
	} edge_t;

	typedef struct packed {
		logic signed [31:0] meas_tx;
		logic signed [31:0] meas_ty;
		logic signed [31:0] meas_tz;
		logic [63:0]        meas_rot;
		logic [31:0]        trans_w;
		logic [31:0]        rot_w;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic               clipped;
	} res_t;

	typedef struct packed {
		logic busy;
		logic held;
	} back_stat_t;

	// one term of a rotation matrix entry: sign and quaternion part indexes
	typedef struct packed {
		logic       neg;
		logic [1:0] ia;
		logic [1:0] ib;
	} mat_term_t;

	// matrix entry e (row major), term t; parts are w=0 x=1 y=2 z=3
	function automatic mat_term_t mat_term(input logic [3:0] e, input logic t);
		mat_term_t m;
		case ({e, t})
			5'd0:    m = '{1'b1, 2'd2, 2'd2};
			5'd1:    m = '{1'b1, 2'd3, 2'd3};
			5'd2:    m = '{1'b0, 2'd1, 2'd2};
			5'd3:    m = '{1'b1, 2'd0, 2'd3};
			5'd4:    m = '{1'b0, 2'd1, 2'd3};
			5'd5:    m = '{1'b0, 2'd0, 2'd2};
			5'd6:    m = '{1'b0, 2'd1, 2'd2};
			5'd7:    m = '{1'b0, 2'd0, 2'd3};
			5'd8:    m = '{1'b1, 2'd1, 2'd1};
			5'd9:    m = '{1'b1, 2'd3, 2'd3};
			5'd10:   m = '{1'b0, 2'd2, 2'd3};
			5'd11:   m = '{1'b1, 2'd0, 2'd1};
			5'd12:   m = '{1'b0, 2'd1, 2'd3};
			5'd13:   m = '{1'b1, 2'd0, 2'd2};
			5'd14:   m = '{1'b0, 2'd2, 2'd3};
			5'd15:   m = '{1'b0, 2'd0, 2'd1};
			5'd16:   m = '{1'b1, 2'd1, 2'd1};
			5'd17:   m = '{1'b1, 2'd2, 2'd2};
			default: m = '{1'b0, 2'd0, 2'd0};
		endcase
		return m;
	endfunction

	// diagonal entries start from one
	function automatic logic mat_one(input logic [3:0] e);
		return (e == 4'd0) || (e == 4'd4) || (e == 4'd8);
	endfunction

	// hamilton product sign of term t in component c (a index t, b index t^c)
	function automatic logic qp_neg(input logic [1:0] c, input logic [1:0] t);
		logic n;
		case ({c, t})
			4'b00_01, 4'b00_10, 4'b00_11: n = 1'b1;
			4'b01_11:                     n = 1'b1;
			4'b10_01:                     n = 1'b1;
			4'b11_10:                     n = 1'b1;
			default:                      n = 1'b0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/rpr_front.sv
// front part: takes items, keeps pose i, queues compute items with their pose pair
module rpr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  rpr_pkg::pose_t      pose,
	output logic                push_valid,
	input  logic                push_stall,
	output rpr_pkg::edge_t      push_data
);

	rpr_pkg::pose_t pi_q;
	logic           acc;

	// stall while the queue is full
	assign in_stall   = push_stall;
	assign acc        = in_valid && !push_stall;
	assign push_valid = acc && (action == rpr_pkg::ACT_COMPUTE);
	assign push_data  = '{pi: pi_q, pj: pose};

	// pose i register, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q <= '0;
		end else if (acc && (action == rpr_pkg::ACT_STORE)) begin
			pi_q <= pose;
		end
	end

endmodule

>>> rtl/rpr_fifo.sv
// short queue of edges between the front and back parts
module rpr_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_stall,
	input  rpr_pkg::edge_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rpr_pkg::edge_t pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rpr_pkg::edge_t mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;

	assign push_stall = (cnt_q == CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/rpr_back.sv
// back part: one shared multiply-accumulate stepped through the residual computation
module rpr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                entry_valid,
	output logic                entry_ready,
	input  rpr_pkg::edge_t      entry,
	input  rpr_pkg::cfg_t       cfg,
	output logic                out_valid,
	input  logic                out_stall,
	output rpr_pkg::res_t       res,
	output rpr_pkg::back_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE, S_MAT, S_TRN, S_QB, S_QE, S_RW, S_DONE
	} state_t;

	state_t             state_q;
	logic [3:0]         grp_q;
	logic [3:0]         trm_q;
	logic signed [15:0] qi_q [4];
	logic signed [16:0] ci_q [4];
	logic signed [16:0] cm_q [4];
	logic signed [15:0] qj_q [4];
	logic signed [32:0] d_q [3];
	logic signed [27:0] mr_q [9];
	logic signed [43:0] e_q;
	logic signed [35:0] qb_q [4];
	logic signed [27:0] r_q [3];
	logic signed [79:0] acc_q;
	logic signed [31:0] wk_q [6];
	logic               clip_q;
	rpr_pkg::res_t      out_q;
	logic               out_valid_q;

	logic signed [43:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [61:0] prod;
	logic signed [79:0] pe;
	logic signed [79:0] scaled;
	logic signed [79:0] acc_next;
	logic               mac;
	logic               clr;
	logic               neg;
	logic               dbl;
	logic               sh16;
	logic               base;
	logic               last_trm;
	logic               last_grp;
	logic [3:0]         trm_end;
	logic [3:0]         grp_end;
	logic [1:0]         k;
	logic [3:0]         mi;
	logic [1:0]         qc;
	logic signed [31:0] meas_sel;
	logic signed [79:0] fin;
	logic               out_load;
	rpr_pkg::mat_term_t mt;

	// round half up by s bits
	function automatic logic signed [79:0] rnd(input logic signed [79:0] v, input int s);
		return (v + (80'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic sat_hit(input logic signed [79:0] v);
		return (v > 80'sd2147483647) || (v < -80'sd2147483648);
	endfunction

	function automatic logic signed [31:0] sat_val(input logic signed [79:0] v);
		logic signed [31:0] r;
		if (v > 80'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -80'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign entry_ready = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign res         = out_q;
	assign stat        = '{busy: (state_q != S_IDLE), held: out_valid_q};
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign k   = trm_q[2:1];
	assign mi  = 4'(k * 3) + grp_q;
	assign qc  = grp_q[1:0] + 2'd1;
	assign mt  = rpr_pkg::mat_term(grp_q, trm_q[0]);
	assign fin = rnd(acc_q, 16);

	always_comb begin
		case (grp_q[1:0])
			2'd0:    meas_sel = cfg.meas_tx;
			2'd1:    meas_sel = cfg.meas_ty;
			default: meas_sel = cfg.meas_tz;
		endcase
	end

	// operand selection and step lengths
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mac     = 1'b0;
		clr     = 1'b0;
		neg     = 1'b0;
		dbl     = 1'b0;
		sh16    = 1'b0;
		base    = 1'b0;
		trm_end = 4'd0;
		grp_end = 4'd0;
		case (state_q)
			S_MAT: begin
				trm_end = 4'd2;
				grp_end = 4'd8;
				if (trm_q < 4'd2) begin
					mul_a = 44'(qi_q[mt.ia]);
					mul_b = 18'(qi_q[mt.ib]);
					mac   = 1'b1;
					clr   = (trm_q == 4'd0);
					neg   = mt.neg;
					dbl   = 1'b1;
					base  = rpr_pkg::mat_one(grp_q) && (trm_q == 4'd0);
				end
			end
			S_TRN: begin
				trm_end = 4'd9;
				grp_end = 4'd2;
				if (trm_q < 4'd6) begin
					mul_a = 44'(mr_q[mi]);
					mul_b = trm_q[0] ? 18'($signed(d_q[k][32:16])) : {2'b00, d_q[k][15:0]};
					mac   = 1'b1;
					clr   = (trm_q == 4'd0);
					sh16  = trm_q[0];
				end else if (trm_q == 4'd7) begin
					mul_a = e_q;
					mul_b = {2'b00, cfg.trans_w[15:0]};
					mac   = 1'b1;
					clr   = 1'b1;
				end else if (trm_q == 4'd8) begin
					mul_a = e_q;
					mul_b = {2'b00, cfg.trans_w[31:16]};
					mac   = 1'b1;
					sh16  = 1'b1;
				end
			end
			S_QB: begin
				trm_end = 4'd4;
				grp_end = 4'd3;
				if (trm_q < 4'd4) begin
					mul_a = 44'(cm_q[trm_q[1:0]]);
					mul_b = 18'(ci_q[trm_q[1:0] ^ grp_q[1:0]]);
					mac   = 1'b1;
					clr   = (trm_q == 4'd0);
					neg   = rpr_pkg::qp_neg(grp_q[1:0], trm_q[1:0]);
				end
			end
			S_QE: begin
				trm_end = 4'd4;
				grp_end = 4'd2;
				if (trm_q < 4'd4) begin
					mul_a = 44'(qb_q[trm_q[1:0]]);
					mul_b = 18'(qj_q[trm_q[1:0] ^ qc]);
					mac   = 1'b1;
					clr   = (trm_q == 4'd0);
					neg   = rpr_pkg::qp_neg(qc, trm_q[1:0]);
				end
			end
			S_RW: begin
				trm_end = 4'd2;
				grp_end = 4'd2;
				if (trm_q < 4'd2) begin
					mul_a = 44'(r_q[grp_q[1:0]]);
					mul_b = trm_q[0] ? {2'b00, cfg.rot_w[31:16]} : {2'b00, cfg.rot_w[15:0]};
					mac   = 1'b1;
					clr   = (trm_q == 4'd0);
					sh16  = trm_q[0];
				end
			end
			default: begin
				trm_end = 4'd0;
			end
		endcase
	end

	// shared multiply-accumulate
	assign prod     = mul_a * mul_b;
	assign pe       = 80'(prod);
	assign scaled   = sh16 ? (pe <<< 16) : (dbl ? (pe <<< 1) : pe);
	assign acc_next = (clr ? (base ? (80'sd1 <<< 28) : 80'sd0) : acc_q)
	                + (neg ? -scaled : scaled);
	assign last_trm = (trm_q == trm_end);
	assign last_grp = (grp_q == grp_end);

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			grp_q       <= '0;
			trm_q       <= '0;
			out_valid_q <= 1'b0;
			clip_q      <= 1'b0;
		end else begin
			// output valid: set on a new result, cleared once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mac) begin
				acc_q <= acc_next;
			end
			if ((state_q != S_IDLE) && (state_q != S_DONE)) begin
				if (last_trm) begin
					trm_q <= '0;
					grp_q <= last_grp ? '0 : grp_q + 1'b1;
				end else begin
					trm_q <= trm_q + 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (entry_valid) begin
						qi_q[0] <= entry.pi.qw;
						qi_q[1] <= entry.pi.qx;
						qi_q[2] <= entry.pi.qy;
						qi_q[3] <= entry.pi.qz;
						ci_q[0] <= 17'(entry.pi.qw);
						ci_q[1] <= -17'(entry.pi.qx);
						ci_q[2] <= -17'(entry.pi.qy);
						ci_q[3] <= -17'(entry.pi.qz);
						cm_q[0] <= 17'($signed(cfg.meas_rot[15:0]));
						cm_q[1] <= -17'($signed(cfg.meas_rot[31:16]));
						cm_q[2] <= -17'($signed(cfg.meas_rot[47:32]));
						cm_q[3] <= -17'($signed(cfg.meas_rot[63:48]));
						qj_q[0] <= entry.pj.qw;
						qj_q[1] <= entry.pj.qx;
						qj_q[2] <= entry.pj.qy;
						qj_q[3] <= entry.pj.qz;
						d_q[0]  <= 33'(entry.pj.px) - 33'(entry.pi.px);
						d_q[1]  <= 33'(entry.pj.py) - 33'(entry.pi.py);
						d_q[2]  <= 33'(entry.pj.pz) - 33'(entry.pi.pz);
						clip_q  <= 1'b0;
						grp_q   <= '0;
						trm_q   <= '0;
						state_q <= S_MAT;
					end
				end
				S_MAT: begin
					if (last_trm) begin
						mr_q[grp_q] <= 28'(rnd(acc_q, 8));
						if (last_grp) begin
							state_q <= S_TRN;
						end
					end
				end
				S_TRN: begin
					if (trm_q == 4'd6) begin
						e_q <= 44'(rnd(acc_q, 20) - 80'(meas_sel));
					end
					if (last_trm) begin
						wk_q[grp_q[2:0]] <= sat_val(fin);
						clip_q <= clip_q | sat_hit(fin);
						if (last_grp) begin
							state_q <= S_QB;
						end
					end
				end
				S_QB: begin
					if (last_trm) begin
						qb_q[grp_q[1:0]] <= 36'(acc_q);
						if (last_grp) begin
							state_q <= S_QE;
						end
					end
				end
				S_QE: begin
					if (last_trm) begin
						r_q[grp_q[1:0]] <= 28'(rnd(acc_q, 25));
						if (last_grp) begin
							state_q <= S_RW;
						end
					end
				end
				S_RW: begin
					if (last_trm) begin
						wk_q[3'd3 + grp_q[2:0]] <= sat_val(fin);
						clip_q <= clip_q | sat_hit(fin);
						if (last_grp) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_q   <= '{wk_q[0], wk_q[1], wk_q[2], wk_q[3], wk_q[4], wk_q[5],
						             clip_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/relative_pose_residual_core.sv
// top level of the pose edge residual block: config registers, front, queue and back
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    action, pos_x..pos_z, rot_w..rot_z
//  out      output     out_valid / out_stall  res_tx..res_rz, clipped
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// a store item only updates pose i; a compute item is worked out in the back part
// by the single shared 44x18 multiply-accumulate walking all products in turn.
// the queue lets the front take further items while the back is busy.
// reset clears pose i to zero and loads the register reset values.
// a finished result waits in the output register while the next item is computed.
module relative_pose_residual_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] rot_w,
	input  logic signed [15:0] rot_x,
	input  logic signed [15:0] rot_y,
	input  logic signed [15:0] rot_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] res_tx,
	output logic signed [31:0] res_ty,
	output logic signed [31:0] res_tz,
	output logic signed [31:0] res_rx,
	output logic signed [31:0] res_ry,
	output logic signed [31:0] res_rz,
	output logic               clipped,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	rpr_pkg::cfg_t       cfg_q;
	rpr_pkg::pose_t      pose;
	rpr_pkg::edge_t      push_data;
	rpr_pkg::edge_t      pop_data;
	rpr_pkg::res_t       res;
	rpr_pkg::back_stat_t bk_stat;
	logic                push_valid;
	logic                push_stall;
	logic                pop_valid;
	logic                pop_ready;

	assign pose = '{pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.meas_tx  <= '0;
			cfg_q.meas_ty  <= '0;
			cfg_q.meas_tz  <= '0;
			cfg_q.meas_rot <= 64'd16384;
			cfg_q.trans_w  <= 32'd65536;
			cfg_q.rot_w    <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				rpr_pkg::REG_MEAS_TX:  cfg_q.meas_tx  <= cfg_data[31:0];
				rpr_pkg::REG_MEAS_TY:  cfg_q.meas_ty  <= cfg_data[31:0];
				rpr_pkg::REG_MEAS_TZ:  cfg_q.meas_tz  <= cfg_data[31:0];
				rpr_pkg::REG_MEAS_ROT: cfg_q.meas_rot <= cfg_data;
				rpr_pkg::REG_TRANS_W:  cfg_q.trans_w  <= cfg_data[31:0];
				rpr_pkg::REG_ROT_W:    cfg_q.rot_w    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	rpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.pose       (pose),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data)
	);

	rpr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rpr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (pop_valid),
		.entry_ready (pop_ready),
		.entry       (pop_data),
		.cfg         (cfg_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res         (res),
		.stat        (bk_stat)
	);

	assign res_tx  = res.tx;
	assign res_ty  = res.ty;
	assign res_tz  = res.tz;
	assign res_rx  = res.rx;
	assign res_ry  = res.ry;
	assign res_rz  = res.rz;
	assign clipped = res.clipped;

	// a store item never enters the queue
	a_store_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (action == rpr_pkg::ACT_STORE)) |-> !push_valid)
		else $error("store item pushed into queue");

	// the front never pushes into a full queue
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !push_stall)
		else $error("push into full queue");

	// no result appears out of an idle back part with an empty queue
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!pop_valid && !bk_stat.busy) |=> !$rose(out_valid))
		else $error("result without queued item");

	// the back part only leaves idle by taking a queued item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!bk_stat.busy && !pop_valid) |=> !bk_stat.busy)
		else $error("back part started without item");

endmodule
